>>> src/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants for the scalar Kalman filter core
// Widths of the fixed-point fields, command and register codes, sequencer
// states.
// ----------------------------------------------------------------------------
package skf_pkg;

	localparam int DATA_WIDTH      = 32;
	localparam int DT_WIDTH        = 16;
	localparam int GAIN_BITS       = 16;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam int MUL_A_WIDTH = DATA_WIDTH + 1;
	localparam int MUL_B_WIDTH = GAIN_BITS + 1;
	localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;

	localparam int DIV_STEPS     = GAIN_BITS + 1;
	localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

	localparam int IN_TDATA_WIDTH  = ((DATA_WIDTH + DT_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8;

	localparam logic [MUL_B_WIDTH-1:0] GAIN_ONE = MUL_B_WIDTH'(1) << GAIN_BITS;
	localparam logic [DATA_WIDTH-1:0]  DATA_MAX = '1;

	localparam logic CMD_UPDATE  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE     = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE = CFG_INDEX_WIDTH'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GROW,
		ST_SUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MOVE,
		ST_APPLY,
		ST_SHRINK,
		ST_DONE
	} skf_state_t;

endpackage

>>> src/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul: shared unsigned multiplier
// One product per enabled cycle, registered before use.
// ----------------------------------------------------------------------------
module skf_mul
	import skf_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  logic [MUL_A_WIDTH-1:0] a,
	input  logic [MUL_B_WIDTH-1:0] b,
	output logic [MUL_P_WIDTH-1:0] product
);

	logic [MUL_P_WIDTH-1:0] product_q;

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= MUL_P_WIDTH'(a) * MUL_P_WIDTH'(b);
		end
	end

	assign product = product_q;

endmodule

>>> src/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div: restoring gain divider
// Forms floor(p * 2^16 / sum) one quotient bit per cycle; a zero divisor
// gives a zero gain.
// ----------------------------------------------------------------------------
module skf_div
	import skf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DATA_WIDTH-1:0]  dividend,
	input  logic [DATA_WIDTH:0]    divisor,
	output logic                   done,
	output logic [MUL_B_WIDTH-1:0] quotient
);

	logic [DATA_WIDTH+1:0]    rem_q;
	logic [DATA_WIDTH:0]      divisor_q;
	logic [MUL_B_WIDTH-1:0]   quo_q;
	logic [DIV_CNT_WIDTH-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic                     zero_q;
	logic [DATA_WIDTH+2:0]    diff;
	logic                     quo_bit;
	logic [DATA_WIDTH+1:0]    rem_keep;

	always_comb begin
		diff     = {1'b0, rem_q} - {2'b00, divisor_q};
		quo_bit  = ~diff[DATA_WIDTH+2];
		rem_keep = quo_bit ? diff[DATA_WIDTH+1:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_WIDTH'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= (DATA_WIDTH+2)'(dividend);
			divisor_q <= divisor;
			zero_q    <= (divisor == '0);
			quo_q     <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_keep[DATA_WIDTH:0], 1'b0};
			quo_q <= {quo_q[MUL_B_WIDTH-2:0], quo_bit};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : quo_q;

endmodule

>>> src/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core: one-dimensional Kalman filter, fixed point
// Grows the covariance by Q*dt, forms the gain P/(P+R) with a serial divider,
// moves the estimate by the gain times the innovation and shrinks P.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | tuser: command; tdata: measurement, elapsed_time
//   m_*      | out       | tdata: estimate, covariance
//   cfg_*    | in        | cfg_index: register, cfg_data: value
//
// An update runs the grow, sum, divide, move, apply and shrink states, a
// restart none; the 17-step gain divider sets most of an update's run. Items
// are taken one at a time. Reset clears the estimate, covariance and
// registers and arms the first sample flag. A finished result waits in the
// output register while the next item is taken in and worked on.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core
	import skf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic                       s_tuser,    // command
	input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,    // measurement, elapsed_time
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_TDATA_WIDTH-1:0] m_tdata,    // estimate, covariance
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]      cfg_data
);

	skf_state_t state_q, state_d;

	logic [DATA_WIDTH-1:0]  q_q, r_q;
	logic [DATA_WIDTH-1:0]  x_q, p_q, z_q;
	logic [DATA_WIDTH:0]    sum_q;
	logic [DT_WIDTH-1:0]    dt_q;
	logic                   first_q;
	logic                   m_tvalid_q;
	logic [DATA_WIDTH-1:0]  est_out_q, cov_out_q;

	logic                   in_accept, out_free;
	logic                   mul_en, div_start, div_done;
	logic [MUL_A_WIDTH-1:0] mul_a;
	logic [MUL_B_WIDTH-1:0] mul_b;
	logic [MUL_P_WIDTH-1:0] mul_p;
	logic [MUL_B_WIDTH-1:0] gain;

	logic [DATA_WIDTH:0]    grown, innov, mag, nx;
	logic [DATA_WIDTH-1:0]  p_sat;
	logic                   innov_neg;

	logic [DATA_WIDTH-1:0]  s_meas;
	logic [DT_WIDTH-1:0]    s_dt;

	assign s_meas    = s_tdata[DATA_WIDTH-1:0];
	assign s_dt      = s_tdata[DATA_WIDTH +: DT_WIDTH];
	assign in_accept = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid_q | m_tready;
	assign cfg_ready = 1'b1;

	skf_mul u_mul (
		.clk     (clk),
		.en      (mul_en),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p)
	);

	skf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (p_q),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (gain)
	);

	always_comb begin
		grown     = {1'b0, p_q} + {1'b0, mul_p[DT_WIDTH +: DATA_WIDTH]};
		p_sat     = grown[DATA_WIDTH] ? DATA_MAX : grown[DATA_WIDTH-1:0];
		innov     = {z_q[DATA_WIDTH-1], z_q} - {x_q[DATA_WIDTH-1], x_q};
		innov_neg = innov[DATA_WIDTH];
		mag       = innov_neg ? (~innov + 1'b1) : innov;
		nx        = innov_neg ? ({x_q[DATA_WIDTH-1], x_q} - mul_p[GAIN_BITS +: DATA_WIDTH+1])
		                      : ({x_q[DATA_WIDTH-1], x_q} + mul_p[GAIN_BITS +: DATA_WIDTH+1]);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (s_tuser == CMD_RESTART) ? ST_DONE : ST_GROW;
				end
			end
			ST_GROW:      state_d = ST_SUM;
			ST_SUM:       state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_MOVE;
				end
			end
			ST_MOVE:      state_d = ST_APPLY;
			ST_APPLY:     state_d = ST_SHRINK;
			ST_SHRINK:    state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		mul_a     = {1'b0, q_q};
		mul_b     = MUL_B_WIDTH'(dt_q);
		unique case (state_q)
			ST_IDLE:      s_tready = 1'b1;
			ST_GROW:      mul_en = 1'b1;
			ST_DIV_START: div_start = 1'b1;
			ST_MOVE: begin
				mul_en = 1'b1;
				mul_a  = mag;
				mul_b  = gain;
			end
			ST_APPLY: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, p_q};
				mul_b  = gain;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			q_q        <= '0;
			r_q        <= '0;
			x_q        <= '0;
			p_q        <= '0;
			first_q    <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PROCESS_NOISE:     q_q <= cfg_data;
					REG_MEASUREMENT_NOISE: r_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (s_tuser == CMD_RESTART) begin
							x_q     <= '0;
							p_q     <= '0;
							first_q <= 1'b1;
						end else if (first_q) begin
							x_q     <= s_meas;
							first_q <= 1'b0;
						end
					end
				end
				ST_SUM:    p_q <= p_sat;
				ST_APPLY:  x_q <= nx[DATA_WIDTH-1:0];
				ST_SHRINK: p_q <= p_q - mul_p[GAIN_BITS +: DATA_WIDTH];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			z_q  <= s_meas;
			dt_q <= s_dt;
		end
		if (state_q == ST_SUM) begin
			sum_q <= {1'b0, p_sat} + {1'b0, r_q};
		end
		if (state_q == ST_DONE && out_free) begin
			est_out_q <= x_q;
			cov_out_q <= p_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_WIDTH'({cov_out_q, est_out_q});

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("gain divider finished outside its wait state");

	a_gain_at_most_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE |-> gain <= GAIN_ONE)
		else $error("gain exceeds one");

	a_shrink_not_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHRINK |=> p_q <= $past(p_q))
		else $error("covariance grew while shrinking");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && s_tuser == CMD_RESTART |=> x_q == '0 && p_q == '0 && first_q)
		else $error("restart left filter state behind");

endmodule
